FILE: design/emdc_pkg.sv
// Shared widths, types and helpers for the equal-mass disk collision core.
package emdc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW   = 32;
  localparam int RW   = 31;
  localparam int NW   = 33;
  localparam int NNW  = 64;
  localparam int DOTW = 67;
  localparam int PW   = 100;
  localparam int QW   = 100;

  typedef struct packed {
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
    logic signed [VW-1:0] v2x;
    logic signed [VW-1:0] v2y;
  } vel_t;

  function automatic logic signed [VW-1:0] sat32(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] hi;
    logic signed [QW+1:0] lo;
    hi = (QW+2)'(32'sh7fffffff);
    lo = -(QW+2)'(64'sh80000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[VW-1:0];
  endfunction

endpackage

FILE: design/equal_mass_disk_collision_core.sv
// Top level of the equal-mass elastic disk collision pipeline.
// Usage: present one disk pair per word on in_* with in_valid; take
// new velocities and the collided flag on out_* when out_valid is high.
// Each word is independent. The pipeline accepts one word every cycle
// while in_ready is high. It is 3 front stages, two product stages (split
// partial products of |n_c|*|dot|, then their sum), 100 divider stages
// (one quotient bit each, set by the 100-bit n_c*dot numerator) and one
// output stage.
// The whole pipeline advances only when the output register is free or
// being emptied, so a receiver stall freezes every stage and nothing is
// lost or repeated; in_ready follows that same advance signal.
// Reset (rst_n low, synchronous) clears every valid bit; data registers
// are left as they are.
module equal_mass_disk_collision_core import emdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] in_pos1_x, in_pos1_y, in_vel1_x, in_vel1_y,
  input  logic [RW-1:0]        in_radius1,
  input  logic signed [VW-1:0] in_pos2_x, in_pos2_y, in_vel2_x, in_vel2_y,
  input  logic [RW-1:0]        in_radius2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] out_new_vel1_x, out_new_vel1_y,
  output logic signed [VW-1:0] out_new_vel2_x, out_new_vel2_y,
  output logic                 out_collided
);
  localparam int DL = PW;
  localparam int SPL = 34;
  logic adv;
  vel_t vin, vf;
  logic vf_v, hit_f;
  logic signed [NW-1:0] nx_f, ny_f;
  logic [NNW-1:0] nn_f;
  logic signed [DOTW-1:0] dot_f;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign vin = '{in_vel1_x, in_vel1_y, in_vel2_x, in_vel2_y};

  emdc_front u_front (
    .clk, .rst_n, .adv, .in_v(in_valid),
    .p1x(in_pos1_x), .p1y(in_pos1_y), .p2x(in_pos2_x), .p2y(in_pos2_y),
    .vel(vin), .r1(in_radius1), .r2(in_radius2),
    .out_v(vf_v), .vel_o(vf), .nx_o(nx_f), .ny_o(ny_f), .nn_o(nn_f),
    .hit_o(hit_f), .dot_o(dot_f)
  );

  // product stage 1: partial products of |dot| * |n_c|, split at bit SPL
  logic        vq_r, hq_r, sxq_r, syq_r;
  vel_t        velq_r;
  logic [NNW-1:0] nnq_r;
  logic [SPL+NW-1:0]      plx_r, ply_r;
  logic [DOTW-SPL+NW-1:0] phx_r, phy_r;
  logic [DOTW-1:0] dm;
  logic [NW-1:0]   mx, my;
  always_comb begin
    dm = dot_f[DOTW-1] ? DOTW'(-dot_f) : DOTW'(dot_f);
    mx = nx_f[NW-1] ? NW'(-nx_f) : NW'(nx_f);
    my = ny_f[NW-1] ? NW'(-ny_f) : NW'(ny_f);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (adv) begin
      vq_r <= vf_v;
    end
    if (adv) begin
      hq_r <= hit_f; velq_r <= vf;
      nnq_r <= hit_f ? nn_f : 64'd1;
      sxq_r <= nx_f[NW-1] ^ dot_f[DOTW-1];
      syq_r <= ny_f[NW-1] ^ dot_f[DOTW-1];
      plx_r <= (SPL+NW)'(dm[SPL-1:0]) * (SPL+NW)'(mx);
      ply_r <= (SPL+NW)'(dm[SPL-1:0]) * (SPL+NW)'(my);
      phx_r <= (DOTW-SPL+NW)'(dm[DOTW-1:SPL]) * (DOTW-SPL+NW)'(mx);
      phy_r <= (DOTW-SPL+NW)'(dm[DOTW-1:SPL]) * (DOTW-SPL+NW)'(my);
    end
  end

  // product stage 2: sum the partial products
  logic        vp_r, hp_r, sxp_r, syp_r;
  vel_t        velp_r;
  logic [NNW-1:0] nnp_r;
  logic [PW-1:0]  px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= vq_r;
    end
    if (adv) begin
      hp_r <= hq_r; velp_r <= velq_r;
      nnp_r <= nnq_r;
      sxp_r <= sxq_r;
      syp_r <= syq_r;
      px_r <= (PW'(phx_r) << SPL) + PW'(plx_r);
      py_r <= (PW'(phy_r) << SPL) + PW'(ply_r);
    end
  end

  logic [QW-1:0] qx, qy;
  emdc_div u_divx (.clk, .adv, .num(px_r), .den(nnp_r), .quo(qx));
  emdc_div u_divy (.clk, .adv, .num(py_r), .den(nnp_r), .quo(qy));

  // side delay line for valid, hit, signs and velocities
  logic dv_r [DL];
  logic dh_r [DL];
  logic dsx_r [DL];
  logic dsy_r [DL];
  vel_t dvel_r [DL];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= vp_r;
      for (int i = 1; i < DL; i++) dv_r[i] <= dv_r[i-1];
    end
    if (adv) begin
      dh_r[0] <= hp_r; dsx_r[0] <= sxp_r; dsy_r[0] <= syp_r; dvel_r[0] <= velp_r;
      for (int i = 1; i < DL; i++) begin
        dh_r[i] <= dh_r[i-1]; dsx_r[i] <= dsx_r[i-1];
        dsy_r[i] <= dsy_r[i-1]; dvel_r[i] <= dvel_r[i-1];
      end
    end
  end

  logic signed [QW+1:0] sqx, sqy;
  vel_t ve;
  logic he;
  always_comb begin
    ve = dvel_r[DL-1];
    he = dh_r[DL-1];
    sqx = dsx_r[DL-1] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    sqy = dsy_r[DL-1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_r[DL-1];
    end
    if (adv) begin
      out_collided <= he;
      out_new_vel1_x <= he ? sat32((QW+2)'(ve.v1x) + sqx) : ve.v1x;
      out_new_vel1_y <= he ? sat32((QW+2)'(ve.v1y) + sqy) : ve.v1y;
      out_new_vel2_x <= he ? sat32((QW+2)'(ve.v2x) - sqx) : ve.v2x;
      out_new_vel2_y <= he ? sat32((QW+2)'(ve.v2y) - sqy) : ve.v2y;
    end
  end
endmodule

FILE: design/emdc_front.sv
// Difference vectors, squared distance, radius bound and dot product stages.
module emdc_front import emdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_v,
  input  logic signed [VW-1:0]  p1x, p1y, p2x, p2y,
  input  vel_t                  vel,
  input  logic [RW-1:0]         r1, r2,
  output logic                  out_v,
  output vel_t                  vel_o,
  output logic signed [NW-1:0]  nx_o, ny_o,
  output logic [NNW-1:0]        nn_o,
  output logic                  hit_o,
  output logic signed [DOTW-1:0] dot_o
);
  // stage A: differences
  logic                 va_r;
  vel_t                 vela_r;
  logic signed [NW-1:0] nxa_r, nya_r, dxa_r, dya_r;
  logic [RW:0]          rsa_r;
  // stage B: products
  logic                 vb_r;
  vel_t                 velb_r;
  logic signed [NW-1:0] nxb_r, nyb_r;
  logic [65:0]          sqx_r, sqy_r;
  logic [63:0]          rrb_r;
  logic signed [65:0]   dpx_r, dpy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; out_v <= 1'b0;
    end else if (adv) begin
      va_r <= in_v; vb_r <= va_r; out_v <= vb_r;
    end
    if (adv) begin
      vela_r <= vel;
      nxa_r <= NW'(p2x) - NW'(p1x);
      nya_r <= NW'(p2y) - NW'(p1y);
      dxa_r <= NW'(vel.v2x) - NW'(vel.v1x);
      dya_r <= NW'(vel.v2y) - NW'(vel.v1y);
      rsa_r <= {1'b0, r1} + {1'b0, r2};
      velb_r <= vela_r;
      nxb_r <= nxa_r; nyb_r <= nya_r;
      sqx_r <= 66'(nxa_r * nxa_r);
      sqy_r <= 66'(nya_r * nya_r);
      rrb_r <= 64'(rsa_r) * 64'(rsa_r);
      dpx_r <= 66'(dxa_r) * 66'(nxa_r);
      dpy_r <= 66'(dya_r) * 66'(nya_r);
      vel_o <= velb_r;
      nx_o <= nxb_r; ny_o <= nyb_r;
      nn_o <= NNW'(sqx_r + sqy_r);
      hit_o <= ((sqx_r + sqy_r) != 66'd0) && ((67'(sqx_r) + 67'(sqy_r)) < 67'(rrb_r));
      dot_o <= DOTW'(dpx_r) + DOTW'(dpy_r);
    end
  end
endmodule

FILE: design/emdc_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned.
module emdc_div import emdc_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  logic [PW-1:0]   num,
  input  logic [NNW-1:0]  den,
  output logic [QW-1:0]   quo
);
  logic [PW-1:0]  n_r [PW];
  logic [NNW:0]   rem_r [PW];
  logic [NNW-1:0] d_r [PW];

  for (genvar i = 0; i < PW; i++) begin : g_st
    logic [PW-1:0]  n_in;
    logic [NNW:0]   rem_in;
    logic [NNW-1:0] d_in;
    logic [NNW:0]   sh;
    logic           qb;
    logic [NNW:0]   rem_nxt;
    logic [PW-1:0]  n_nxt;
    if (i == 0) begin : g_head
      assign n_in = num;
      assign rem_in = '0;
      assign d_in = den;
    end else begin : g_tail
      assign n_in = n_r[i-1];
      assign rem_in = rem_r[i-1];
      assign d_in = d_r[i-1];
    end
    // quotient bit replaces the numerator bit it consumed
    always_comb begin
      sh = {rem_in[NNW-1:0], n_in[PW-1-i]};
      qb = (sh >= {1'b0, d_in});
      rem_nxt = qb ? sh - {1'b0, d_in} : sh;
      n_nxt = n_in;
      n_nxt[PW-1-i] = qb;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        d_r[i] <= d_in;
        n_r[i] <= n_nxt;
      end
    end
  end
  assign quo = n_r[PW-1];
endmodule

FILE: bench/equal_mass_disk_collision_core_test.sv
// Testbench for the equal-mass disk collision core: random and directed disk pairs.
`timescale 1ns / 100ps
module equal_mass_disk_collision_core_test;
  import emdc_pkg::*;

  typedef struct {
    logic signed [31:0] p1x, p1y, v1x, v1y;
    logic [30:0] r1;
    logic signed [31:0] p2x, p2y, v2x, v2y;
    logic [30:0] r2;
  } disk_pair_t;

  typedef struct {
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic hit;
  } bounce_t;

  // Predicts the velocities after contact and checks them in order.
  class bounce_board;
    bounce_t pending[$];
    int mismatches;

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sh7fffffff) return 32'sh7fffffff;
      if (v < -128'sh80000000) return 32'sh80000000;
      return v[31:0];
    endfunction

    function automatic logic signed [127:0] normal_shift(logic signed [127:0] nc,
        logic signed [127:0] dot, logic [127:0] nn);
      logic [127:0] pm;
      logic [127:0] q;
      logic signed [127:0] p;
      p = nc * dot;
      pm = p < 0 ? -p : p;
      q = pm / nn;
      return p < 0 ? -$signed(q) : $signed(q);
    endfunction

    function void note_pair(disk_pair_t d);
      bounce_t e;
      logic signed [127:0] nx, ny, dot, qx, qy;
      logic [127:0] nn, rr, rs;
      nx = $signed(d.p2x) - $signed(d.p1x);
      ny = $signed(d.p2y) - $signed(d.p1y);
      nn = nx * nx + ny * ny;
      rs = {97'd0, d.r1} + {97'd0, d.r2};
      rr = rs * rs;
      e.v1x = d.v1x; e.v1y = d.v1y; e.v2x = d.v2x; e.v2y = d.v2y; e.hit = 0;
      if (nn != 0 && nn < rr) begin
        dot = ($signed({{96{d.v2x[31]}}, d.v2x}) - d.v1x) * nx
            + ($signed({{96{d.v2y[31]}}, d.v2y}) - d.v1y) * ny;
        qx = normal_shift(nx, dot, nn);
        qy = normal_shift(ny, dot, nn);
        e.v1x = clamp32(d.v1x + qx);
        e.v1y = clamp32(d.v1y + qy);
        e.v2x = clamp32(d.v2x - qx);
        e.v2y = clamp32(d.v2y - qy);
        e.hit = 1;
      end
      pending.push_back(e);
    endfunction

    function void check_word(bounce_t got);
      bounce_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
        return;
      end
      e = pending.pop_front();
      if (got.v1x !== e.v1x || got.v1y !== e.v1y || got.v2x !== e.v2x ||
          got.v2y !== e.v2y || got.hit !== e.hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                   e.v1x, e.v1y, e.v2x, e.v2y, e.hit,
                   got.v1x, got.v1y, got.v2x, got.v2y, got.hit);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, out_collided;
  logic signed [31:0] in_pos1_x = 0, in_pos1_y = 0, in_vel1_x = 0, in_vel1_y = 0;
  logic signed [31:0] in_pos2_x = 0, in_pos2_y = 0, in_vel2_x = 0, in_vel2_y = 0;
  logic [30:0] in_radius1 = 0, in_radius2 = 0;
  logic signed [31:0] out_new_vel1_x, out_new_vel1_y, out_new_vel2_x, out_new_vel2_y;
  bounce_board board = new();
  int cycles = 0;
  bit sending = 1;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  equal_mass_disk_collision_core dut (.*);

  always @(posedge clk) begin
    bounce_t got;
    cycles++;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got.v1x = out_new_vel1_x; got.v1y = out_new_vel1_y;
      got.v2x = out_new_vel2_x; got.v2y = out_new_vel2_y;
      got.hit = out_collided;
      board.check_word(got);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, with calm stretches.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 7) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
        end
      end
      out_ready <= 1;
    end
  end

  task automatic send_pair(disk_pair_t d);
    in_pos1_x <= d.p1x; in_pos1_y <= d.p1y; in_vel1_x <= d.v1x; in_vel1_y <= d.v1y;
    in_radius1 <= d.r1;
    in_pos2_x <= d.p2x; in_pos2_y <= d.p2y; in_vel2_x <= d.v2x; in_vel2_y <= d.v2y;
    in_radius2 <= d.r2;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_pair(d);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int g;
    if ($urandom_range(0, 2) == 0) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [31:0] rnd_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom_range(0, 4) == 0 ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic disk_pair_t random_pair();
    disk_pair_t d;
    int mode;
    mode = $urandom_range(0, 9);
    d.p1x = $urandom; d.p1y = $urandom;
    d.v1x = rnd_word(mode < 8 ? 0 : 2); d.v1y = rnd_word(mode % 3 == 0 ? 1 : 0);
    d.v2x = rnd_word(mode < 8 ? 0 : 2); d.v2y = rnd_word(0);
    d.r1 = 31'($urandom); d.r2 = 31'($urandom);
    if (mode < 7) begin
      // keep the second disk close enough to overlap most of the time
      d.r1 = 31'($urandom_range(0, 1 << ($urandom_range(4, 30))));
      d.r2 = 31'($urandom_range(0, 1 << ($urandom_range(4, 30))));
      d.p2x = d.p1x + $signed($urandom_range(0, d.r1 + 1)) - $signed(d.r1 / 2);
      d.p2y = d.p1y + $signed($urandom_range(0, d.r2 + 1)) - $signed(d.r2 / 2);
    end else begin
      d.p2x = $urandom; d.p2y = $urandom;
    end
    return d;
  endfunction

  initial begin
    disk_pair_t d;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // coincident centres
    d = '{100, 200, 5, 6, 1000, 100, 200, -7, 8, 1000};
    send_pair(d);
    // touching exactly, then apart, then zero radii
    d = '{0, 0, 65536, 0, 65536, 131072, 0, -65536, 0, 65536};
    send_pair(d);
    d.p2x = 131073; send_pair(d);
    d.r1 = 0; d.r2 = 0; send_pair(d);
    // head-on overlap
    d = '{0, 0, 65536, 0, 65536, 65536, 0, -65536, 0, 65536};
    send_pair(d);
    // extreme positions and velocities, saturation
    d = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff};
    send_pair(d);
    d = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
          32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'h7fffffff};
    send_pair(d);
    d = '{0, 0, 32'sh7fffffff, 32'sh7fffffff, 10, 1, 1, 32'sh80000000, 32'sh80000000, 10};
    send_pair(d);
    d = '{-1, -1, -1, -1, 31'h7fffffff, 0, 0, 0, 0, 0};
    send_pair(d);
    d = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_pair(d);
    for (int i = 0; i < 850; i++) begin
      if (i == 400) begin
        // hold until the pipeline drains
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
      end
      idle_gap();
      send_pair(random_pair());
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: equal_mass_disk_collision_core.f
design/emdc_pkg.sv
design/emdc_front.sv
design/emdc_div.sv
design/equal_mass_disk_collision_core.sv
bench/equal_mass_disk_collision_core_test.sv
